@@ hw/rtl/uer_pkg.sv @@
// Shared types, codes and constants for the ultrasonic echo ranger.
// Holds the phase and status enums, the item layouts and a small helper.
// No dependencies.
package uer_pkg;

  // Trigger timing, in ticks
  localparam int unsigned PRE_LOW_TICKS   = 2;
  localparam int unsigned TRIG_HIGH_TICKS = 10;

  // Register reset values and the index of each register
  localparam int unsigned CNT_W          = 16;
  localparam logic [CNT_W-1:0] WAIT_LIMIT_RST  = 16'd10000;
  localparam logic [CNT_W-1:0] WIDTH_LIMIT_RST = 16'd3883;
  localparam logic REG_WAIT_LIMIT  = 1'b0;
  localparam logic REG_WIDTH_LIMIT = 1'b1;

  // Distance scale: cm per tick in Q8, (ticks * 3372) >> 8
  localparam int unsigned DIST_W     = 20;
  localparam int unsigned PROD_W     = 28;
  localparam int unsigned DIST_SHIFT = 8;
  localparam logic [11:0] DIST_SCALE = 12'd3372;

  // Sensor choices
  localparam logic [1:0] SENS_FRONT   = 2'd0;
  localparam logic [1:0] SENS_RIGHT   = 2'd1;
  localparam logic [1:0] SENS_LEFT    = 2'd2;
  localparam logic [1:0] SENS_INVALID = 2'd3;

  // Packed bus widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LOW  = 3'd1,
    PH_HIGH = 3'd2,
    PH_WAIT = 3'd3,
    PH_MEAS = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_SENSOR = 2'd1,
    ST_NO_ECHO    = 2'd2,
    ST_RANGE      = 2'd3
  } status_t;

  // One tick item
  typedef struct packed {
    logic       echo_left;
    logic       echo_right;
    logic       echo_front;
    logic [1:0] sensor_select;
    logic       start_req;
  } tick_t;

  // One result item
  typedef struct packed {
    logic [DIST_W-1:0] distance_q8;
    logic [CNT_W-1:0]  echo_ticks;
    status_t           status;
    logic              done_res;
    logic              busy_res;
    logic              trigger;
  } result_t;

  // Counter increment that sticks at all ones
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + 1'b1;
  endfunction

endpackage

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: trigger sequencing, echo wait, echo width count
// and distance scaling, one tick item in and one result item out.
// Depends on uer_pkg.
//
// A tick accepted into the input register is processed, the distance
// multiply included, and its result goes to the output register.
// Throughput: one tick per clock while the output is not stalled; the input
// register takes a new tick while the previous result waits.
// Reset (rst_n low, synchronous): idle phase, counters and sensor cleared,
// limits back to 10000 and 3883, both pipeline stages empty.
module ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] start_req, [2:1] sensor_select, [3] echo_front, [4] echo_right,
  // [5] echo_left, [7:6] zero
  input  logic [uer_pkg::IN_TDATA_W-1:0]    in_tdata,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] trigger, [1] busy_res, [2] done_res, [4:3] status,
  // [20:5] echo_ticks, [40:21] distance_q8, [47:41] zero
  output logic [uer_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic                              cfg_index,
  input  logic [uer_pkg::CNT_W-1:0]         cfg_data
);

  localparam int unsigned CW = uer_pkg::CNT_W;

  // Configuration registers
  logic [CW-1:0] wait_limit_r;
  logic [CW-1:0] width_limit_r;

  // Pipeline registers
  logic           s1_valid_r;
  uer_pkg::tick_t s1_tick_r;
  logic           out_valid_r;
  uer_pkg::result_t out_res_r;
  uer_pkg::result_t res_nxt;

  // Ranger state
  uer_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      sensor_r, sensor_nxt;
  logic [CW-1:0]   phase_cnt_r, phase_cnt_nxt;
  logic [CW-1:0]   width_cnt_r, width_cnt_nxt;

  logic                             advance;
  logic                             s2_fire;
  logic                             echo;
  logic [uer_pkg::PROD_W-1:0]       prod;

  // Output stage loads when empty or drained; input stage follows it
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign s2_fire    = s1_valid_r && advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(uer_pkg::OUT_TDATA_W - $bits(uer_pkg::result_t)){1'b0}}, out_res_r};

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_limit_r  <= uer_pkg::WAIT_LIMIT_RST;
      width_limit_r <= uer_pkg::WIDTH_LIMIT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        uer_pkg::REG_WAIT_LIMIT:  wait_limit_r  <= cfg_data;
        uer_pkg::REG_WIDTH_LIMIT: width_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_tick_r <= uer_pkg::tick_t'(in_tdata[$bits(uer_pkg::tick_t)-1:0]);
    end
  end

  // Hold state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= uer_pkg::PH_IDLE;
      sensor_r    <= uer_pkg::SENS_FRONT;
      phase_cnt_r <= '0;
      width_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s2_fire) begin
        phase_r     <= phase_nxt;
        sensor_r    <= sensor_nxt;
        phase_cnt_r <= phase_cnt_nxt;
        width_cnt_r <= width_cnt_nxt;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_res_r <= res_nxt;
    end
  end

  // Distance scale; only used when the count is the registered one
  assign prod = uer_pkg::PROD_W'(width_cnt_r) * uer_pkg::PROD_W'(uer_pkg::DIST_SCALE);

  // Next state and result for one tick
  always_comb begin
    phase_nxt     = phase_r;
    sensor_nxt    = sensor_r;
    phase_cnt_nxt = phase_cnt_r;
    width_cnt_nxt = width_cnt_r;
    res_nxt       = '0;
    res_nxt.status = uer_pkg::ST_OK;

    // Start only from idle; an invalid sensor finishes at once
    if (phase_r == uer_pkg::PH_IDLE && s1_tick_r.start_req) begin
      if (s1_tick_r.sensor_select == uer_pkg::SENS_INVALID) begin
        res_nxt.done_res = 1'b1;
        res_nxt.status   = uer_pkg::ST_BAD_SENSOR;
      end else begin
        sensor_nxt    = s1_tick_r.sensor_select;
        phase_nxt     = uer_pkg::PH_LOW;
        phase_cnt_nxt = '0;
        width_cnt_nxt = '0;
      end
    end

    // Select the echo line of the latched sensor
    case (sensor_nxt)
      uer_pkg::SENS_FRONT: echo = s1_tick_r.echo_front;
      uer_pkg::SENS_RIGHT: echo = s1_tick_r.echo_right;
      uer_pkg::SENS_LEFT:  echo = s1_tick_r.echo_left;
      default:             echo = 1'b0;
    endcase

    // Trigger sequence and echo wait
    unique case (phase_nxt)
      uer_pkg::PH_LOW: begin
        res_nxt.busy_res = 1'b1;
        phase_cnt_nxt = uer_pkg::sat_inc(phase_cnt_nxt);
        if (phase_cnt_nxt >= CW'(uer_pkg::PRE_LOW_TICKS)) begin
          phase_nxt     = uer_pkg::PH_HIGH;
          phase_cnt_nxt = '0;
        end
      end
      uer_pkg::PH_HIGH: begin
        res_nxt.busy_res = 1'b1;
        res_nxt.trigger  = 1'b1;
        phase_cnt_nxt = uer_pkg::sat_inc(phase_cnt_nxt);
        if (phase_cnt_nxt >= CW'(uer_pkg::TRIG_HIGH_TICKS)) begin
          phase_nxt     = uer_pkg::PH_WAIT;
          phase_cnt_nxt = '0;
        end
      end
      uer_pkg::PH_WAIT: begin
        res_nxt.busy_res = 1'b1;
        if (echo) begin
          phase_nxt     = uer_pkg::PH_MEAS;
          width_cnt_nxt = '0;
        end else if (phase_cnt_nxt > wait_limit_r || (&phase_cnt_nxt)) begin
          res_nxt.busy_res = 1'b0;
          res_nxt.done_res = 1'b1;
          res_nxt.status   = uer_pkg::ST_NO_ECHO;
          phase_nxt        = uer_pkg::PH_IDLE;
          phase_cnt_nxt    = '0;
        end else begin
          phase_cnt_nxt = uer_pkg::sat_inc(phase_cnt_nxt);
        end
      end
      uer_pkg::PH_IDLE, uer_pkg::PH_MEAS: ;
      default: ;
    endcase

    // Measure echo width; a tick entering from the wait counts too
    if (phase_nxt == uer_pkg::PH_MEAS) begin
      res_nxt.busy_res = 1'b1;
      if (echo) begin
        if (width_cnt_nxt > width_limit_r || (&width_cnt_nxt)) begin
          res_nxt.busy_res   = 1'b0;
          res_nxt.done_res   = 1'b1;
          res_nxt.status     = uer_pkg::ST_RANGE;
          res_nxt.echo_ticks = width_cnt_nxt;
          phase_nxt          = uer_pkg::PH_IDLE;
        end else begin
          width_cnt_nxt = uer_pkg::sat_inc(width_cnt_nxt);
        end
      end else begin
        // Echo low here means the phase was already measuring last tick
        res_nxt.busy_res    = 1'b0;
        res_nxt.done_res    = 1'b1;
        res_nxt.status      = uer_pkg::ST_OK;
        res_nxt.echo_ticks  = width_cnt_r;
        res_nxt.distance_q8 = prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];
        phase_nxt           = uer_pkg::PH_IDLE;
      end
    end
  end

  // Checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.done_res && out_res_r.busy_res))
    else $error("done and busy reported together");

  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.trigger) |-> out_res_r.busy_res)
    else $error("trigger driven outside a measurement");

  a_sensor_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != uer_pkg::PH_IDLE) |-> (sensor_r != uer_pkg::SENS_INVALID))
    else $error("measurement running on invalid sensor");

  a_dist_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.distance_q8 != '0) |->
      (out_res_r.done_res && out_res_r.status == uer_pkg::ST_OK))
    else $error("distance reported without a good measurement");

endmodule
